// File: rtl/acctilt_pkg.sv
// ----------------------------------------------------------------------------
// acctilt_pkg: shared types and constants for the tilt angle pipeline
// Arctangent table in degrees times 2^24 and the axis mode type.
// ----------------------------------------------------------------------------
package acctilt_pkg;

    localparam int ACC_BITS  = 24;
    localparam int TABLE_LEN = 24;
    localparam int GUARD     = 8;

    typedef logic [1:0] t_mode;
    localparam t_mode MODE_ROLL  = 2'd0;
    localparam t_mode MODE_PITCH = 2'd1;

    function automatic logic [31:0] atan_deg(input int i);
        logic [31:0] r;
        case (i)
            0:  r = 32'd754974720;
            1:  r = 32'd445687602;
            2:  r = 32'd235489088;
            3:  r = 32'd119537938;
            4:  r = 32'd60000934;
            5:  r = 32'd30029717;
            6:  r = 32'd15018523;
            7:  r = 32'd7509720;
            8:  r = 32'd3754917;
            9:  r = 32'd1877466;
            10: r = 32'd938734;
            11: r = 32'd469367;
            12: r = 32'd234684;
            13: r = 32'd117342;
            14: r = 32'd58671;
            15: r = 32'd29335;
            16: r = 32'd14668;
            17: r = 32'd7334;
            18: r = 32'd3667;
            19: r = 32'd1833;
            20: r = 32'd917;
            21: r = 32'd458;
            22: r = 32'd229;
            23: r = 32'd115;
            default: r = 32'd0;
        endcase
        return r;
    endfunction

endpackage

// File: rtl/accel_tilt_angle.sv
// ----------------------------------------------------------------------------
// accel_tilt_angle: roll / negated pitch from one accelerometer sample
// Squares, a 24-step restoring square root, CORDIC vectoring, rounding.
// ----------------------------------------------------------------------------
// One word in and one word out per cycle while the output is not stalled. The
// stages (CORDIC_STAGES capped at 24) are two for axis select and squares,
// a load stage and one result bit per stage for the square root, a load stage
// and one iteration per stage for CORDIC, and the output register.
// The whole pipeline advances only when the
// output register is empty or being taken, so a stall holds every stage.
module accel_tilt_angle #(
    parameter int CORDIC_STAGES   = 16,
    parameter int ANGLE_FRAC_BITS = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic signed [15:0] i_accel_x,
    input  logic signed [15:0] i_accel_y,
    input  logic signed [15:0] i_accel_z,
    input  acctilt_pkg::t_mode i_mode,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [15:0] o_angle
);
    import acctilt_pkg::*;

    localparam int NST  = (CORDIC_STAGES > TABLE_LEN) ? TABLE_LEN : CORDIC_STAGES;
    localparam int SQN  = 24;           // result bits of sqrt(sum * 2^16)
    localparam int RW   = 50;           // remainder width
    localparam int CW   = 44;           // cordic x/y width
    localparam int ZW   = 34;
    localparam int SH   = ACC_BITS - ANGLE_FRAC_BITS;
    localparam int LIMR = 90 << ANGLE_FRAC_BITS;
    localparam int LIM  = (LIMR > 32767) ? 32767 : LIMR;

    logic adv;
    assign adv     = !o_valid || i_ready;
    assign o_ready = adv;

    // stage 0: select axes, stage 1: squares and sum
    logic               r_v0, r_v1;
    logic               r_en0, r_en1;
    logic signed [15:0] r_p0, r_a0, r_b0, r_p1;
    logic        [31:0] r_sq1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
        end else if (adv) begin
            r_v0 <= i_valid;
            r_v1 <= r_v0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_en0 <= (i_mode == MODE_ROLL) || (i_mode == MODE_PITCH);
            r_p0  <= (i_mode == MODE_ROLL) ? i_accel_y : i_accel_x;
            r_a0  <= (i_mode == MODE_ROLL) ? i_accel_x : i_accel_y;
            r_b0  <= i_accel_z;
            r_en1 <= r_en0;
            r_p1  <= r_p0;
            r_sq1 <= 32'(r_a0 * r_a0) + 32'(r_b0 * r_b0);
        end
    end

    // square root: operand sum*2^16 (48 bits), one result bit per stage
    logic              r_sv [SQN+1];
    logic              r_sen [SQN+1];
    logic signed [15:0] r_sp [SQN+1];
    logic [47:0]       r_sop [SQN+1];
    logic [RW-1:0]     r_srem [SQN+1];
    logic [SQN-1:0]    r_sq [SQN+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_sv[0] <= 1'b0;
        else if (adv) r_sv[0] <= r_v1;
    end
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_sen[0]  <= r_en1;
            r_sp[0]   <= r_p1;
            r_sop[0]  <= {r_sq1, 16'd0};
            r_srem[0] <= '0;
            r_sq[0]   <= '0;
        end
    end

    for (genvar k = 0; k < SQN; k++) begin : g_sqrt
        logic [RW-1:0] rem2, trial;
        logic          take;
        assign rem2  = {r_srem[k][RW-3:0], r_sop[k][47:46]};
        assign trial = rem2 - {{(RW-SQN-2){1'b0}}, r_sq[k], 2'b01};
        assign take  = !trial[RW-1];
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_sv[k+1] <= 1'b0;
            else if (adv) r_sv[k+1] <= r_sv[k];
        end
        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_sen[k+1]  <= r_sen[k];
                r_sp[k+1]   <= r_sp[k];
                r_sop[k+1]  <= {r_sop[k][45:0], 2'b00};
                r_srem[k+1] <= take ? trial : rem2;
                r_sq[k+1]   <= {r_sq[k][SQN-2:0], take};
            end
        end
    end

    // CORDIC vectoring
    logic                 r_cv [NST+1];
    logic                 r_cen [NST+1];
    logic                 r_cz0 [NST+1];
    logic signed [CW-1:0] r_cx [NST+1];
    logic signed [CW-1:0] r_cy [NST+1];
    logic signed [ZW-1:0] r_cz [NST+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_cv[0] <= 1'b0;
        else if (adv) r_cv[0] <= r_sv[SQN];
    end
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_cen[0] <= r_sen[SQN];
            r_cz0[0] <= (r_sq[SQN] == '0) && (r_sp[SQN] == '0);
            r_cx[0]  <= CW'(signed'({1'b0, r_sq[SQN]}));
            r_cy[0]  <= CW'(signed'({r_sp[SQN], 8'd0}));
            r_cz[0]  <= '0;
        end
    end

    for (genvar i = 0; i < NST; i++) begin : g_cordic
        logic signed [CW-1:0] dx, dy;
        logic signed [ZW-1:0] at;
        assign dx = r_cy[i] >>> i;
        assign dy = r_cx[i] >>> i;
        assign at = ZW'(atan_deg(i));
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_cv[i+1] <= 1'b0;
            else if (adv) r_cv[i+1] <= r_cv[i];
        end
        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_cen[i+1] <= r_cen[i];
                r_cz0[i+1] <= r_cz0[i];
                if (!r_cy[i][CW-1]) begin
                    r_cx[i+1] <= r_cx[i] + dx;
                    r_cy[i+1] <= r_cy[i] - dy;
                    r_cz[i+1] <= r_cz[i] + at;
                end else begin
                    r_cx[i+1] <= r_cx[i] - dx;
                    r_cy[i+1] <= r_cy[i] + dy;
                    r_cz[i+1] <= r_cz[i] - at;
                end
            end
        end
    end

    // rounding and clamp
    logic signed [ZW-1:0] rnd;
    logic signed [15:0]   n_angle;
    assign rnd = (r_cz[NST] + ZW'(1 << (SH - 1))) >>> SH;
    always_comb begin
        if (!r_cen[NST] || r_cz0[NST]) n_angle = '0;
        else if (rnd > ZW'(LIM))       n_angle = 16'(LIM);
        else if (rnd < -ZW'(LIM))      n_angle = -16'(LIM);
        else                           n_angle = rnd[15:0];
    end

    logic               r_ov;
    logic signed [15:0] r_angle;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ov <= 1'b0;
        else if (adv) r_ov <= r_cv[NST];
    end
    always_ff @(posedge i_clk) begin
        if (adv) r_angle <= n_angle;
    end
    assign o_valid = r_ov;
    assign o_angle = r_angle;

endmodule

// File: rtl/acctilt_checker.sv
// ----------------------------------------------------------------------------
// acctilt_checker: port-level checks for accel_tilt_angle
// Handshake hold, output range and ready while the output is empty.
// ----------------------------------------------------------------------------
module acctilt_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               o_ready,
    input logic               o_valid,
    input logic               i_ready,
    input logic signed [15:0] o_angle
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_angle)) else $error("out word dropped");
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_angle <= 16'sd23040) && (o_angle >= -16'sd23040))
        else $error("angle out of range");
    a_rdy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready) else $error("not ready while output empty");
endmodule

bind accel_tilt_angle acctilt_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
    .o_valid(o_valid), .i_ready(i_ready), .o_angle(o_angle)
);
